// ----- design/bus_activity_led_color_core_defines.svh -----
// -----------------------------------------------------------------------------
// Bus activity status pixel - assertion macros
// Shared concurrent check forms, clocked on clock and quiet during reset.
// -----------------------------------------------------------------------------
`ifndef BUS_ACTIVITY_LED_COLOR_CORE_DEFINES_SVH
`define BUS_ACTIVITY_LED_COLOR_CORE_DEFINES_SVH

// expression holds at every edge out of reset
`define BAC_ASSERT_HOLDS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("bac: check failed");

// consequent holds in the same cycle as the antecedent
`define BAC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bac: check failed");

`endif

// ----- design/bac_pkg.sv -----
// -----------------------------------------------------------------------------
// Bus activity status pixel - package
// Widths, codes, colours and shared types of the status pixel core.
// -----------------------------------------------------------------------------
package bac_pkg;

   localparam int LEVEL_WIDTH = 24;                 // activity level, Q8
   localparam int TIME_W      = 32;
   localparam int CNT_W       = 16;
   localparam int COL_W       = 8;
   localparam int THR_W       = 17;
   localparam int DECAY_W     = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   // serial multiplier geometry
   localparam int MCAND_W  = LEVEL_WIDTH + 1;
   localparam int MPLIER_W = 16;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int MSTEP_W  = $clog2(MPLIER_W + 1);

   // level update sum: decayed level plus count shifted into Q8
   localparam int SUM_W = ((LEVEL_WIDTH > CNT_W + 8) ? LEVEL_WIDTH : CNT_W + 8) + 1;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

   localparam logic [COL_W-1:0] BASE_MAX   = 8'd80;
   localparam logic [COL_W-1:0] BLINK_HIGH = 8'd120;
   localparam logic [COL_W-1:0] BLINK_LOW  = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_MS        = 3'd0,
      CSR_PEAK_MS        = 3'd1,
      CSR_BURST_THRESH   = 3'd2,
      CSR_LINK_PERIOD_MS = 3'd3,
      CSR_LINK_FLASH_MS  = 3'd4,
      CSR_DECAY_Q8       = 3'd5,
      CSR_GAIN_Q8        = 3'd6,
      CSR_BLINK_MS       = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      HEALTH_OK       = 2'd0,
      HEALTH_DEGRADED = 2'd1,
      HEALTH_ERROR    = 2'd2,
      HEALTH_BUS_OFF  = 2'd3
   } health_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LINK,
      ST_MODE,
      ST_TIMERS,
      ST_RX_MUL,
      ST_RX_WAIT,
      ST_TX_MUL,
      ST_TX_WAIT,
      ST_GAIN_MUL,
      ST_GAIN_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
   } color_type;

   localparam color_type COL_YELLOW = '{red: 8'd150, green: 8'd150, blue: 8'd0};
   localparam color_type COL_RED    = '{red: 8'd150, green: 8'd0,   blue: 8'd0};
   localparam color_type COL_ORANGE = '{red: 8'd80,  green: 8'd30,  blue: 8'd0};
   localparam color_type COL_WHITE  = '{red: 8'd100, green: 8'd100, blue: 8'd100};

   typedef struct packed {
      logic [15:0]          hold_ms;
      logic [15:0]          peak_ms;
      logic [THR_W-1:0]     burst_thresh;
      logic [15:0]          link_period_ms;
      logic [15:0]          link_flash_ms;
      logic [DECAY_W-1:0]   decay_q8;
      logic [15:0]          gain_q8;
      logic [15:0]          blink_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hold_ms:        16'd20,
      peak_ms:        16'd40,
      burst_thresh:   17'd50,
      link_period_ms: 16'd1000,
      link_flash_ms:  16'd25,
      decay_q8:       8'd230,
      gain_q8:        16'd410,
      blink_ms:       16'd200
   };

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] rx_level;
      logic [LEVEL_WIDTH-1:0] tx_level;
      logic [TIME_W-1:0]      rx_hold_until;
      logic [TIME_W-1:0]      tx_hold_until;
      logic [TIME_W-1:0]      peak_hold_until;
      logic [TIME_W-1:0]      next_flash_at;
      logic [TIME_W-1:0]      flash_end_at;
      logic [TIME_W-1:0]      blink_mark;
      logic                   blink_on;
      logic [CNT_W-1:0]       pending_rx;
      logic [CNT_W-1:0]       pending_tx;
   } track_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   // floor(level * decay / 256) + cnt * 256, saturated to the level range
   function automatic logic [LEVEL_WIDTH-1:0] level_update(
      input logic [PROD_W-1:0] prod,
      input logic [CNT_W-1:0]  cnt
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(prod[LEVEL_WIDTH+7:8]) + SUM_W'({cnt, 8'd0});
      if (sum > SUM_W'(LEVEL_MAX)) begin
         level_update = LEVEL_MAX;
      end else begin
         level_update = sum[LEVEL_WIDTH-1:0];
      end
   endfunction

endpackage

// ----- design/bac_sermul.sv -----
// -----------------------------------------------------------------------------
// Bus activity status pixel - bit-serial multiplier
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module bac_sermul
   import bac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [MSTEP_W-1:0] step_ff, step_in;
   logic               done_ff, done_in;
   logic [MCAND_W:0]   partial;

   // upper half gains the multiplicand when the bit under test is set
   assign partial = {1'b0, prod_ff[PROD_W-1:MPLIER_W]}
                  + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         prod_in  = {{MCAND_W{1'b0}}, mul_req.mplier};
         mcand_in = mul_req.mcand;
         step_in  = MSTEP_W'(MPLIER_W);
      end else if (step_ff != '0) begin
         prod_in = {partial, prod_ff[MPLIER_W-1:1]};
         step_in = step_ff - MSTEP_W'(1);
         done_in = (step_ff == MSTEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign mul_rsp.busy    = (step_ff != '0);
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

endmodule

// ----- design/bus_activity_led_color_core.sv -----
// -----------------------------------------------------------------------------
// Bus activity status pixel - core
// Turns one refresh tick of bus activity into one RGB status colour.
// -----------------------------------------------------------------------------
// One word on req_ is one refresh tick; one word on rsp_ is the colour for it.
// Ticks are handled one at a time. An override tick (link-down flash, bus off,
// error blink, degraded) passes through the link, mode and emit states, and
// the next tick is taken once the sequencer is back in idle. A normal tick
// runs three products through the bit-serial multiplier (rx decay, tx decay,
// brightness gain), each of 16 shift-and-add steps; that multiplier sets the
// rate. The result sits in an output register, so a stalled rsp_ word does
// not stop the next tick from being taken. Configuration writes land at once
// and should only be made while no tick is in flight.

`include "bus_activity_led_color_core_defines.svh"

module bus_activity_led_color_core
   import bac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick in
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [CNT_W-1:0]      req_rx_count,
   input  logic [CNT_W-1:0]      req_tx_count,
   input  logic                  req_link_up,
   input  logic [1:0]            req_bus_health,
   // colour out
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COL_W-1:0]      rsp_red,
   output logic [COL_W-1:0]      rsp_green,
   output logic [COL_W-1:0]      rsp_blue,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type   state_ff, state_in;
   cfg_type     cfg_ff, cfg_in;
   track_type   trk_ff, trk_in;

   // latched tick
   logic [TIME_W-1:0] now_ff, now_in;
   logic              link_ff, link_in;
   health_type        health_ff, health_in;
   logic [CNT_W-1:0]  cnt_rx_ff, cnt_rx_in;   // counts with pending folded in
   logic [CNT_W-1:0]  cnt_tx_ff, cnt_tx_in;

   color_type   col_ff, col_in;
   color_type   rsp_col_ff, rsp_col_in;
   logic        rsp_valid_ff, rsp_valid_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // working values of the combinational block
   logic                   blink_next;
   logic [MCAND_W-1:0]     base_wide;
   logic [COL_W-1:0]       base;
   logic [COL_W-1:0]       base_q;
   logic                   rx_act, tx_act, peak_act;
   logic                   mul_wait;

   bac_sermul u_sermul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_col_ff.red;
   assign rsp_green = rsp_col_ff.green;
   assign rsp_blue  = rsp_col_ff.blue;

   // sequencer is parked on a product
   assign mul_wait = (state_ff == ST_RX_WAIT) || (state_ff == ST_TX_WAIT) ||
                     (state_ff == ST_GAIN_WAIT);

   // --- configuration registers ---------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HOLD_MS:        cfg_in.hold_ms        = csr_wdata[15:0];
            CSR_PEAK_MS:        cfg_in.peak_ms        = csr_wdata[15:0];
            CSR_BURST_THRESH:   cfg_in.burst_thresh   = csr_wdata[THR_W-1:0];
            CSR_LINK_PERIOD_MS: cfg_in.link_period_ms = csr_wdata[15:0];
            CSR_LINK_FLASH_MS:  cfg_in.link_flash_ms  = csr_wdata[15:0];
            CSR_DECAY_Q8:       cfg_in.decay_q8       = csr_wdata[DECAY_W-1:0];
            CSR_GAIN_Q8:        cfg_in.gain_q8        = csr_wdata[15:0];
            CSR_BLINK_MS:       cfg_in.blink_ms       = csr_wdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // --- tick sequencer ------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      trk_in     = trk_ff;
      now_in     = now_ff;
      link_in    = link_ff;
      health_in  = health_ff;
      cnt_rx_in  = cnt_rx_ff;
      cnt_tx_in  = cnt_tx_ff;
      col_in     = col_ff;
      rsp_col_in = rsp_col_ff;
      mul_req    = '0;
      blink_next = trk_ff.blink_on;

      // brightness from the gain product, clipped at the base ceiling
      base_wide = mul_rsp.product[PROD_W-1:MPLIER_W];
      base      = (base_wide > MCAND_W'(BASE_MAX)) ? BASE_MAX : base_wide[COL_W-1:0];
      base_q    = base >> 2;
      rx_act    = (now_ff < trk_ff.rx_hold_until);
      tx_act    = (now_ff < trk_ff.tx_hold_until);
      peak_act  = (now_ff < trk_ff.peak_hold_until);

      // taken word leaves the output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in    = req_now_ms;
               link_in   = req_link_up;
               health_in = health_type'(req_bus_health);
               cnt_rx_in = trk_ff.pending_rx + req_rx_count;
               cnt_tx_in = trk_ff.pending_tx + req_tx_count;
               state_in  = ST_LINK;
            end
         end

         ST_LINK: begin
            // a flash window opens once per period while the link is down
            if (!link_ff && (now_ff >= trk_ff.next_flash_at)) begin
               trk_in.next_flash_at = now_ff + TIME_W'(cfg_ff.link_period_ms);
               trk_in.flash_end_at  = now_ff + TIME_W'(cfg_ff.link_flash_ms);
            end
            state_in = ST_MODE;
         end

         ST_MODE: begin
            // counts stay pending unless this turns out to be a normal tick
            trk_in.pending_rx = cnt_rx_ff;
            trk_in.pending_tx = cnt_tx_ff;
            state_in          = ST_EMIT;
            if (!link_ff && (now_ff < trk_ff.flash_end_at)) begin
               col_in = COL_YELLOW;
            end else begin
               unique case (health_ff)
                  HEALTH_BUS_OFF: col_in = COL_RED;
                  HEALTH_ERROR: begin
                     if ((now_ff - trk_ff.blink_mark) > TIME_W'(cfg_ff.blink_ms)) begin
                        trk_in.blink_mark = now_ff;
                        blink_next        = !trk_ff.blink_on;
                     end
                     trk_in.blink_on = blink_next;
                     col_in.red      = blink_next ? BLINK_HIGH : BLINK_LOW;
                     col_in.green    = '0;
                     col_in.blue     = '0;
                  end
                  HEALTH_DEGRADED: col_in = COL_ORANGE;
                  HEALTH_OK: begin
                     trk_in.pending_rx = '0;
                     trk_in.pending_tx = '0;
                     state_in          = ST_TIMERS;
                  end
                  default: col_in = COL_RED;
               endcase
            end
         end

         ST_TIMERS: begin
            if (cnt_rx_ff != '0) begin
               trk_in.rx_hold_until = now_ff + TIME_W'(cfg_ff.hold_ms);
            end
            if (cnt_tx_ff != '0) begin
               trk_in.tx_hold_until = now_ff + TIME_W'(cfg_ff.hold_ms);
            end
            if (({1'b0, cnt_rx_ff} + {1'b0, cnt_tx_ff}) > cfg_ff.burst_thresh) begin
               trk_in.peak_hold_until = now_ff + TIME_W'(cfg_ff.peak_ms);
            end
            state_in = ST_RX_MUL;
         end

         ST_RX_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = MCAND_W'(trk_ff.rx_level);
            mul_req.mplier = MPLIER_W'(cfg_ff.decay_q8);
            state_in       = ST_RX_WAIT;
         end

         ST_RX_WAIT: begin
            if (mul_rsp.done) begin
               trk_in.rx_level = level_update(mul_rsp.product, cnt_rx_ff);
               state_in        = ST_TX_MUL;
            end
         end

         ST_TX_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = MCAND_W'(trk_ff.tx_level);
            mul_req.mplier = MPLIER_W'(cfg_ff.decay_q8);
            state_in       = ST_TX_WAIT;
         end

         ST_TX_WAIT: begin
            if (mul_rsp.done) begin
               trk_in.tx_level = level_update(mul_rsp.product, cnt_tx_ff);
               state_in        = ST_GAIN_MUL;
            end
         end

         ST_GAIN_MUL: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {1'b0, trk_ff.rx_level} + {1'b0, trk_ff.tx_level};
            mul_req.mplier = cfg_ff.gain_q8;
            state_in       = ST_GAIN_WAIT;
         end

         ST_GAIN_WAIT: begin
            if (mul_rsp.done) begin
               // peak burst wins, then rx/tx pulse colours, dim idle teal last
               if (peak_act) begin
                  col_in = COL_WHITE;
               end else if (rx_act && tx_act) begin
                  col_in = '{red: '0, green: base, blue: base};
               end else if (rx_act) begin
                  col_in = '{red: '0, green: '0, blue: base};
               end else if (tx_act) begin
                  col_in = '{red: '0, green: base, blue: '0};
               end else begin
                  col_in = '{red: '0, green: base_q, blue: base_q};
               end
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_col_in   = col_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         trk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         trk_ff       <= trk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff     <= now_in;
      link_ff    <= link_in;
      health_ff  <= health_in;
      cnt_rx_ff  <= cnt_rx_in;
      cnt_tx_ff  <= cnt_tx_in;
      col_ff     <= col_in;
      rsp_col_ff <= rsp_col_in;
   end

   // --- checks --------------------------------------------------------------
   // the multiplier only finishes while the sequencer waits for it
   `BAC_ASSERT_IMPLIES(a_mul_done_in_wait, mul_rsp.done, mul_wait)
   // a new word appears only out of the emit step
   `BAC_ASSERT_IMPLIES(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT)
   // a normal tick has consumed its pending counts
   `BAC_ASSERT_IMPLIES(a_pending_cleared, state_ff == ST_TIMERS, {trk_ff.pending_rx, trk_ff.pending_tx} == '0)
   // no colour exceeds the brightest fixed colours
   `BAC_ASSERT_IMPLIES(a_colour_range, rsp_valid_ff, (rsp_col_ff.blue <= 8'd100) && (rsp_col_ff.red <= 8'd150))

endmodule
